@@ rtl/particle_shaker_synth_assert.svh @@
// ---------------------------------------------------------------------------
// Particle shaker assertion macros
// Concurrent assertion helpers; they expand to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef PARTICLE_SHAKER_SYNTH_ASSERT_SVH
`define PARTICLE_SHAKER_SYNTH_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is active.
`define PSS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("particle_shaker_synth: same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define PSS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("particle_shaker_synth: next-cycle check failed");

`else

`define PSS_ASSERT_IMP(label, clk, rstn, ante, cons)
`define PSS_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/pss_pkg.sv @@
// ---------------------------------------------------------------------------
// Particle shaker package
// Shared types, codes and fixed-point constants of the shaker voice.
// ---------------------------------------------------------------------------
package pss_pkg;

    // Default signal width (s31.16 held in two's complement)
    localparam int SIGNAL_WIDTH_DEF = 48;

    // Shared multiplier geometry: 33 x 33 signed, operand A split in two halves
    localparam int MUL_A_W  = 64;
    localparam int MUL_OP_W = 33;
    localparam int MUL_P_W  = 2 * MUL_OP_W;
    localparam int PROD_W   = MUL_P_W + 32;

    // Input commands
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_ADD   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_VOICE_MODE = 3'd0,
        CFG_THRESHOLD  = 3'd1,
        CFG_GAIN       = 3'd2,
        CFG_A1         = 3'd3,
        CFG_A2         = 3'd4,
        CFG_SND_DECAY  = 3'd5,
        CFG_SYS_DECAY  = 3'd6
    } cfg_idx_t;

    // Voice modes (the unused code behaves as maraca)
    localparam logic [1:0] MODE_MARACA = 2'd0;
    localparam logic [1:0] MODE_SEKERE = 2'd1;
    localparam logic [1:0] MODE_CABASA = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_SUM,
        ST_APPLY,
        ST_DIFF,
        ST_OUT
    } state_t;

    // Multiply operations of one tick, in order
    typedef enum logic [2:0] {
        OP_SYS_DECAY,
        OP_GAIN,
        OP_NOISE,
        OP_SND_DECAY,
        OP_FB1,
        OP_FB2,
        OP_SCALE
    } op_t;

    // Register reset values
    localparam logic [1:0]         VOICE_MODE_RST = 2'd0;
    localparam logic [10:0]        THRESHOLD_RST  = 11'd25;
    localparam logic [27:0]        GAIN_RST       = 28'd62329035;
    localparam logic signed [31:0] A1_RST         = -32'sd1262924396;
    localparam logic signed [31:0] A2_RST         = 32'sd989560465;
    localparam logic [30:0]        SND_DECAY_RST  = 31'd1020054733;
    localparam logic [30:0]        SYS_DECAY_RST  = 31'd1072668082;

    // Energy cap 2000.0 in s31.16
    localparam logic [26:0] ENERGY_CAP = 27'd131072000;

    // Output scale 0.0001 * 2^7 in Q0.30, and its double
    localparam logic signed [MUL_OP_W-1:0] OUT_SCALE    = 33'sd13743895;
    localparam logic signed [MUL_OP_W-1:0] OUT_SCALE_X2 = 33'sd27487791;

    // Noise offset: noise = draw - 16384 in Q1.14
    localparam logic signed [15:0] NOISE_OFFSET = 16'sd16384;

    // Q1.23 sample limits
    localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] SAMPLE_MIN = -24'sh800000;

endpackage

@@ rtl/particle_shaker_synth.sv @@
// ---------------------------------------------------------------------------
// Particle shaker voice
// Maraca, sekere and cabasa particle synthesis on one shared multiplier.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (s_valid/s_ready): one transaction carries a command, an
//    energy amount and two random draws. Set, add and clear commands update
//    the shake energy in the accept cycle and return no result.
//  - A tick runs seven fixed-point multiplications on one 33x33 multiplier:
//    six pass through low half, high half, sum with floor shift and
//    saturation, and write-back or saturating add/sub; the output scale
//    skips the write-back. A difference step comes before the output scale,
//    and an output step after it offers the sample transaction.
//  - Energy commands are taken one per cycle while idle; a new tick waits
//    until the last one has left its output step. s_ready is high only while idle.
//  - Result channel (m_valid/m_ready): an output register holds the sample;
//    the next item is accepted while it waits. If a new sample is done
//    while the old one is still held, the sequencer holds in its output
//    cycle until the receiver takes it.
//  - Reset clears energy, sound level, resonator and delay line, empties
//    the output register and loads the register defaults.
//  - Configuration (cfg_wr_en/cfg_index/cfg_wdata): the user must write it only
//    while idle, which the block does not enforce; writes to unknown indexes are dropped.
// ---------------------------------------------------------------------------
module particle_shaker_synth #(
    parameter int SIGNAL_WIDTH = pss_pkg::SIGNAL_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [18:0] s_energy_amount,
    input  logic [9:0]  s_collision_draw,
    input  logic [14:0] s_noise_draw,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [23:0] m_sample
);

`include "particle_shaker_synth_assert.svh"

    localparam int W  = SIGNAL_WIDTH;
    localparam int PW = pss_pkg::PROD_W;
    localparam int OW = pss_pkg::MUL_OP_W;

    localparam logic signed [W-1:0]  SIG_MAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  SIG_MIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [PW-1:0] SIG_MAX_P = PW'(SIG_MAX);
    localparam logic signed [PW-1:0] SIG_MIN_P = PW'(SIG_MIN);
    localparam logic signed [W-1:0]  CAP_W     = W'(pss_pkg::ENERGY_CAP);
    localparam logic signed [W-1:0]  SMP_MAX_W = W'(pss_pkg::SAMPLE_MAX);
    localparam logic signed [W-1:0]  SMP_MIN_W = W'(pss_pkg::SAMPLE_MIN);

    // Configuration registers
    logic [1:0]         mode_reg;
    logic [10:0]        thr_reg;
    logic [27:0]        gain_reg;
    logic signed [31:0] a1_reg;
    logic signed [31:0] a2_reg;
    logic [30:0]        snd_dec_reg;
    logic [30:0]        sys_dec_reg;

    // Voice state
    logic signed [W-1:0] e_reg, e_next;
    logic signed [W-1:0] l_reg, l_next;
    logic signed [W-1:0] x_reg, x_next;
    logic signed [W-1:0] h0_reg, h0_next;
    logic signed [W-1:0] h1_reg, h1_next;
    logic signed [W-1:0] z0_reg, z0_next;
    logic signed [W-1:0] z1_reg, z1_next;
    logic signed [W-1:0] z2_reg, z2_next;
    logic signed [W-1:0] d_reg, d_next;
    logic signed [W-1:0] mres_reg, mres_next;

    // Sequencer and item latches
    pss_pkg::state_t state_reg, state_next;
    pss_pkg::op_t    op_reg, op_next;
    logic            coll_reg, coll_next;
    logic signed [15:0] noise_reg, noise_next;

    // Multiplier partial products
    logic signed [pss_pkg::MUL_P_W-1:0] p_lo_reg, p_lo_next;
    logic signed [pss_pkg::MUL_P_W-1:0] p_hi_reg, p_hi_next;

    // Output register
    logic               m_valid_reg, m_valid_next;
    logic signed [23:0] m_sample_reg, m_sample_next;

    // Shared arithmetic
    logic signed [W-1:0]                op_a;
    logic signed [OW-1:0]               op_b;
    logic signed [pss_pkg::MUL_A_W-1:0] a64;
    logic signed [OW-1:0]               mul_x;
    logic signed [pss_pkg::MUL_P_W-1:0] mul_p;
    logic signed [PW-1:0]               prod_full;
    logic signed [PW-1:0]               prod_shr;
    logic signed [W-1:0]                prod_sat;

    logic signed [W-1:0] as_a, as_b;
    logic                as_sub;
    logic signed [W:0]   as_wide;
    logic signed [W-1:0] as_res;

    logic signed [W:0]   add_sum;
    logic                s_fire;

    assign s_ready  = (state_reg == pss_pkg::ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

    // Configuration writes; drop unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= pss_pkg::VOICE_MODE_RST;
            thr_reg     <= pss_pkg::THRESHOLD_RST;
            gain_reg    <= pss_pkg::GAIN_RST;
            a1_reg      <= pss_pkg::A1_RST;
            a2_reg      <= pss_pkg::A2_RST;
            snd_dec_reg <= pss_pkg::SND_DECAY_RST;
            sys_dec_reg <= pss_pkg::SYS_DECAY_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pss_pkg::CFG_VOICE_MODE: mode_reg    <= cfg_wdata[1:0];
                pss_pkg::CFG_THRESHOLD:  thr_reg     <= cfg_wdata[10:0];
                pss_pkg::CFG_GAIN:       gain_reg    <= cfg_wdata[27:0];
                pss_pkg::CFG_A1:         a1_reg      <= $signed(cfg_wdata);
                pss_pkg::CFG_A2:         a2_reg      <= $signed(cfg_wdata);
                pss_pkg::CFG_SND_DECAY:  snd_dec_reg <= cfg_wdata[30:0];
                pss_pkg::CFG_SYS_DECAY:  sys_dec_reg <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // Operand select for the current multiply
    always_comb begin
        op_a = e_reg;
        op_b = $signed({2'b00, sys_dec_reg});
        case (op_reg)
            pss_pkg::OP_SYS_DECAY: begin
                op_a = e_reg;
                op_b = $signed({2'b00, sys_dec_reg});
            end
            pss_pkg::OP_GAIN: begin
                op_a = e_reg;
                op_b = $signed({5'b00000, gain_reg});
            end
            pss_pkg::OP_NOISE: begin
                op_a = l_reg;
                op_b = OW'(noise_reg);
            end
            pss_pkg::OP_SND_DECAY: begin
                op_a = l_reg;
                op_b = $signed({2'b00, snd_dec_reg});
            end
            pss_pkg::OP_FB1: begin
                op_a = h0_reg;
                op_b = OW'(a1_reg);
            end
            pss_pkg::OP_FB2: begin
                op_a = h1_reg;
                op_b = OW'(a2_reg);
            end
            pss_pkg::OP_SCALE: begin
                op_a = d_reg;
                if (mode_reg == pss_pkg::MODE_SEKERE || mode_reg == pss_pkg::MODE_CABASA) begin
                    op_b = pss_pkg::OUT_SCALE_X2;
                end else begin
                    op_b = pss_pkg::OUT_SCALE;
                end
            end
            default: ;
        endcase
    end

    // One 33x33 multiplier: low half of A first, then the signed high half
    assign a64   = pss_pkg::MUL_A_W'(op_a);
    assign mul_x = (state_reg == pss_pkg::ST_LO) ? $signed({1'b0, a64[31:0]})
                                                 : $signed({a64[63], a64[63:32]});
    assign mul_p = mul_x * op_b;

    // Combine halves, floor shift, saturate to the signal range
    always_comb begin
        prod_full = $signed({p_hi_reg, 32'b0}) + PW'(p_lo_reg);
        case (op_reg)
            pss_pkg::OP_GAIN:  prod_shr = prod_full >>> 24;
            pss_pkg::OP_NOISE: prod_shr = prod_full >>> 14;
            default:           prod_shr = prod_full >>> 30;
        endcase
        if (prod_shr > SIG_MAX_P) begin
            prod_sat = SIG_MAX;
        end else if (prod_shr < SIG_MIN_P) begin
            prod_sat = SIG_MIN;
        end else begin
            prod_sat = prod_shr[W-1:0];
        end
    end

    // Shared saturating add/sub
    always_comb begin
        as_a   = x_reg;
        as_b   = mres_reg;
        as_sub = 1'b1;
        if (state_reg == pss_pkg::ST_DIFF) begin
            if (mode_reg == pss_pkg::MODE_SEKERE) begin
                as_a = z0_reg;
                as_b = z2_reg;
            end else begin
                as_a = h0_reg;
                as_b = h1_reg;
            end
        end else if (op_reg == pss_pkg::OP_GAIN) begin
            as_a   = l_reg;
            as_sub = 1'b0;
        end
        as_wide = as_sub ? ((W+1)'(as_a) - (W+1)'(as_b))
                         : ((W+1)'(as_a) + (W+1)'(as_b));
        if (as_wide > (W+1)'(SIG_MAX)) begin
            as_res = SIG_MAX;
        end else if (as_wide < (W+1)'(SIG_MIN)) begin
            as_res = SIG_MIN;
        end else begin
            as_res = as_wide[W-1:0];
        end
    end

    assign add_sum = (W+1)'(e_reg) + $signed({{(W-26){1'b0}}, s_energy_amount, 8'b0});

    // Sequencer: next state and datapath updates
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        coll_next     = coll_reg;
        noise_next    = noise_reg;
        e_next        = e_reg;
        l_next        = l_reg;
        x_next        = x_reg;
        h0_next       = h0_reg;
        h1_next       = h1_reg;
        z0_next       = z0_reg;
        z1_next       = z1_reg;
        z2_next       = z2_reg;
        d_next        = d_reg;
        mres_next     = mres_reg;
        p_lo_next     = p_lo_reg;
        p_hi_next     = p_hi_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_sample_next = m_sample_reg;

        case (state_reg)
            pss_pkg::ST_IDLE: begin
                if (s_fire) begin
                    case (s_command)
                        pss_pkg::CMD_TICK: begin
                            coll_next  = ({1'b0, s_collision_draw} < thr_reg);
                            noise_next = $signed({1'b0, s_noise_draw}) - pss_pkg::NOISE_OFFSET;
                            op_next    = pss_pkg::OP_SYS_DECAY;
                            state_next = pss_pkg::ST_LO;
                        end
                        pss_pkg::CMD_SET: begin
                            e_next = W'({s_energy_amount, 8'b0});
                        end
                        pss_pkg::CMD_ADD: begin
                            // clamp the sum at the cap
                            if (add_sum >= (W+1)'(CAP_W)) begin
                                e_next = CAP_W;
                            end else begin
                                e_next = add_sum[W-1:0];
                            end
                        end
                        default: begin
                            e_next = '0;
                        end
                    endcase
                end
            end
            pss_pkg::ST_LO: begin
                p_lo_next  = mul_p;
                state_next = pss_pkg::ST_HI;
            end
            pss_pkg::ST_HI: begin
                p_hi_next  = mul_p;
                state_next = pss_pkg::ST_SUM;
            end
            pss_pkg::ST_SUM: begin
                mres_next = prod_sat;
                if (op_reg == pss_pkg::OP_SCALE) begin
                    state_next = pss_pkg::ST_OUT;
                end else begin
                    state_next = pss_pkg::ST_APPLY;
                end
            end
            pss_pkg::ST_APPLY: begin
                state_next = pss_pkg::ST_LO;
                case (op_reg)
                    pss_pkg::OP_SYS_DECAY: begin
                        e_next  = mres_reg;
                        op_next = pss_pkg::OP_GAIN;
                    end
                    pss_pkg::OP_GAIN: begin
                        if (coll_reg) begin
                            l_next = as_res;
                        end
                        op_next = pss_pkg::OP_NOISE;
                    end
                    pss_pkg::OP_NOISE: begin
                        x_next  = mres_reg;
                        op_next = pss_pkg::OP_SND_DECAY;
                    end
                    pss_pkg::OP_SND_DECAY: begin
                        l_next  = mres_reg;
                        op_next = pss_pkg::OP_FB1;
                    end
                    pss_pkg::OP_FB1: begin
                        x_next  = as_res;
                        op_next = pss_pkg::OP_FB2;
                    end
                    pss_pkg::OP_FB2: begin
                        // advance resonator history and, in sekere mode, the delay line
                        x_next  = as_res;
                        h0_next = as_res;
                        h1_next = h0_reg;
                        if (mode_reg == pss_pkg::MODE_SEKERE) begin
                            z0_next = h0_reg;
                            z1_next = z0_reg;
                            z2_next = z1_reg;
                        end
                        op_next    = pss_pkg::OP_SCALE;
                        state_next = pss_pkg::ST_DIFF;
                    end
                    default: begin
                        state_next = pss_pkg::ST_IDLE;
                    end
                endcase
            end
            pss_pkg::ST_DIFF: begin
                d_next     = as_res;
                state_next = pss_pkg::ST_LO;
            end
            pss_pkg::ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (mres_reg > SMP_MAX_W) begin
                        m_sample_next = pss_pkg::SAMPLE_MAX;
                    end else if (mres_reg < SMP_MIN_W) begin
                        m_sample_next = pss_pkg::SAMPLE_MIN;
                    end else begin
                        m_sample_next = mres_reg[23:0];
                    end
                    state_next = pss_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pss_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and voice state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pss_pkg::ST_IDLE;
            op_reg      <= pss_pkg::OP_SYS_DECAY;
            m_valid_reg <= 1'b0;
            e_reg       <= '0;
            l_reg       <= '0;
            h0_reg      <= '0;
            h1_reg      <= '0;
            z0_reg      <= '0;
            z1_reg      <= '0;
            z2_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
            e_reg       <= e_next;
            l_reg       <= l_next;
            h0_reg      <= h0_next;
            h1_reg      <= h1_next;
            z0_reg      <= z0_next;
            z1_reg      <= z1_next;
            z2_reg      <= z2_next;
        end
    end

    // Working payload registers
    always_ff @(posedge aclk) begin
        coll_reg     <= coll_next;
        noise_reg    <= noise_next;
        x_reg        <= x_next;
        d_reg        <= d_next;
        mres_reg     <= mres_next;
        p_lo_reg     <= p_lo_next;
        p_hi_reg     <= p_hi_next;
        m_sample_reg <= m_sample_next;
    end

    // A tick starts the multiply sequence at its first operation
    `PSS_ASSERT_NXT(a_tick_start, aclk, aresetn,
        s_fire && (s_command == pss_pkg::CMD_TICK),
        (state_reg == pss_pkg::ST_LO) && (op_reg == pss_pkg::OP_SYS_DECAY))

    // A sample appears only out of the output cycle
    `PSS_ASSERT_NXT(a_out_source, aclk, aresetn,
        (state_reg != pss_pkg::ST_OUT) && !m_valid_reg, !m_valid_reg)

    // A saturating add never leaves the energy above the cap
    `PSS_ASSERT_NXT(a_add_cap, aclk, aresetn,
        s_fire && (s_command == pss_pkg::CMD_ADD), e_reg <= CAP_W)

    // Energy commands never start the sequencer
    `PSS_ASSERT_NXT(a_cmd_idle, aclk, aresetn,
        s_fire && (s_command != pss_pkg::CMD_TICK), state_reg == pss_pkg::ST_IDLE)

endmodule
